>>> hdl/tpf_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and codes for the triangle plane fit block.
package tpf_pkg;

	// Store and coordinate geometry
	localparam int VERTEX_DEPTH = 1024;
	localparam int CW           = 32;
	localparam int FRAC         = 16;
	localparam int IDXW         = 10;
	localparam int AW           = $clog2(VERTEX_DEPTH);

	// Arithmetic widths: differences, products, determinant and numerators
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int NW  = PW + 1;
	localparam int SW  = NW + FRAC;
	// Quotient bits kept by the divider; anything larger saturates anyway
	localparam int QB  = CW + 1;
	localparam int CMW = NW + QB;
	localparam int CPW = 2 * CW + 2;
	localparam int DIVLAT = QB + 1;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = QPW + 1;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(CW-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(CW-1){1'b0}}});

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_FIT  = 1'b1
	} cmd_t;

	// Three corners of one fit transaction
	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t z0;
		coord_t x1;
		coord_t y1;
		coord_t z1;
		coord_t x2;
		coord_t y2;
		coord_t z2;
		logic   last;
	} fit_t;

	typedef struct packed {
		logic valid;
		fit_t fit;
	} push_t;

	// Data that rides alongside the dividers
	typedef struct packed {
		coord_t x2;
		coord_t y2;
		coord_t z2;
		logic   last;
		logic   degen;
	} side_t;

endpackage

>>> hdl/tpf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/tpf_front.sv
`timescale 1ns / 1ps
// Front end: accepts transactions, writes vertices, reads the three corners of a fit.
module tpf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    cmd,
	input  logic [tpf_pkg::IDXW-1:0] vertex_index,
	input  tpf_pkg::coord_t         coord_x,
	input  tpf_pkg::coord_t         coord_y,
	input  tpf_pkg::coord_t         coord_z,
	input  logic [tpf_pkg::IDXW-1:0] node_a,
	input  logic [tpf_pkg::IDXW-1:0] node_b,
	input  logic [tpf_pkg::IDXW-1:0] node_c,
	input  logic                    last_in,
	input  logic [tpf_pkg::QCW-1:0] q_level,
	output tpf_pkg::push_t          push
);

	localparam int VW = 3 * tpf_pkg::CW;

	logic          acc;
	logic          fit_acc;
	logic          we;
	logic [VW-1:0] wdata;
	logic [VW-1:0] rd0;
	logic [VW-1:0] rd1;
	logic [VW-1:0] rd2;
	logic          pend_q;
	logic          last_s1;
	logic          oob0_s1;
	logic          oob1_s1;
	logic          oob2_s1;
	logic [tpf_pkg::QCW:0] occ;

	// Hold off while the queue could not take the fits already in flight
	assign occ        = {1'b0, q_level} + {{tpf_pkg::QCW{1'b0}}, pend_q};
	assign item_stall = occ >= (tpf_pkg::QCW+1)'(tpf_pkg::QDEPTH);
	assign acc        = item_valid && !item_stall;
	assign fit_acc    = acc && (cmd == tpf_pkg::CMD_FIT);
	assign we         = acc && (cmd == tpf_pkg::CMD_LOAD)
		&& (int'(vertex_index) < tpf_pkg::VERTEX_DEPTH);
	assign wdata      = {coord_x, coord_y, coord_z};

	// One store copy per corner so all three read in the same cycle
	tpf_ram #(.WIDTH(VW), .DEPTH(tpf_pkg::VERTEX_DEPTH)) u_ram0 (
		.clk(clk), .we(we), .waddr(tpf_pkg::AW'(vertex_index)), .wdata(wdata),
		.raddr(tpf_pkg::AW'(node_a)), .rdata(rd0)
	);
	tpf_ram #(.WIDTH(VW), .DEPTH(tpf_pkg::VERTEX_DEPTH)) u_ram1 (
		.clk(clk), .we(we), .waddr(tpf_pkg::AW'(vertex_index)), .wdata(wdata),
		.raddr(tpf_pkg::AW'(node_b)), .rdata(rd1)
	);
	tpf_ram #(.WIDTH(VW), .DEPTH(tpf_pkg::VERTEX_DEPTH)) u_ram2 (
		.clk(clk), .we(we), .waddr(tpf_pkg::AW'(vertex_index)), .wdata(wdata),
		.raddr(tpf_pkg::AW'(node_c)), .rdata(rd2)
	);

	// Track the fit whose corners arrive next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= fit_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (fit_acc) begin
			last_s1 <= last_in;
			oob0_s1 <= int'(node_a) >= tpf_pkg::VERTEX_DEPTH;
			oob1_s1 <= int'(node_b) >= tpf_pkg::VERTEX_DEPTH;
			oob2_s1 <= int'(node_c) >= tpf_pkg::VERTEX_DEPTH;
		end
	end

	// Form the queue entry; corners beyond the store read as the origin
	always_comb begin
		push.valid = pend_q;
		{push.fit.x0, push.fit.y0, push.fit.z0} = oob0_s1 ? '0 : rd0;
		{push.fit.x1, push.fit.y1, push.fit.z1} = oob1_s1 ? '0 : rd1;
		{push.fit.x2, push.fit.y2, push.fit.z2} = oob2_s1 ? '0 : rd2;
		push.fit.last = last_s1;
	end

	a_fit_push: assert property (@(posedge clk) disable iff (!arst_n)
		fit_acc |=> push.valid)
		else $error("fit transaction did not reach the queue");

endmodule

>>> hdl/tpf_queue.sv
`timescale 1ns / 1ps
// Short queue of fit transactions between front and back.
module tpf_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tpf_pkg::push_t          push,
	input  logic                    pop,
	output logic [tpf_pkg::QCW-1:0] level,
	output logic                    avail,
	output tpf_pkg::fit_t           head
);

	tpf_pkg::fit_t           mem_q [0:tpf_pkg::QDEPTH-1];
	logic [tpf_pkg::QPW-1:0] wptr_q;
	logic [tpf_pkg::QPW-1:0] rptr_q;
	logic [tpf_pkg::QCW-1:0] cnt_q;

	assign level = cnt_q;
	assign avail = cnt_q != '0;
	assign head  = mem_q[rptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {{(tpf_pkg::QCW-1){1'b0}}, push.valid}
				- {{(tpf_pkg::QCW-1){1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wptr_q] <= push.fit;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> cnt_q != tpf_pkg::QCW'(tpf_pkg::QDEPTH))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue read while empty");

endmodule

>>> hdl/tpf_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider of magnitudes, one quotient bit per stage, saturating result.
module tpf_div (
	input  logic                   clk,
	input  logic                   en,
	input  logic [tpf_pkg::SW-1:0] num,
	input  logic [tpf_pkg::NW-1:0] den,
	input  logic                   neg,
	output tpf_pkg::coord_t        quo,
	output logic                   clip
);

	localparam int QB  = tpf_pkg::QB;
	localparam int CMW = tpf_pkg::CMW;
	localparam int CW  = tpf_pkg::CW;

	logic [CMW-1:0]             rem_q [0:QB-1];
	logic [tpf_pkg::NW-1:0]     den_q [0:QB-1];
	logic [QB-1:0]              quo_q [0:QB];
	logic                       ovf_q [0:QB];
	logic                       neg_q [0:QB];
	logic [QB-1:0]              pos_lim;
	logic [QB-1:0]              neg_lim;
	logic [CW-1:0]              mag;

	// Load: flag quotients too large for the kept bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= CMW'(num);
			den_q[0] <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= CMW'(num) >= (CMW'(den) << QB);
			neg_q[0] <= neg;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar i = 1; i <= QB; i++) begin : g_step
		localparam int K = QB - i;
		logic [CMW-1:0] trial;
		logic           take;

		assign trial = CMW'(den_q[i-1]) << K;
		assign take  = rem_q[i-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[i] <= quo_q[i-1] | (take ? (QB'(1) << K) : '0);
				ovf_q[i] <= ovf_q[i-1];
				neg_q[i] <= neg_q[i-1];
			end
		end

		if (i < QB) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i] <= take ? rem_q[i-1] - trial : rem_q[i-1];
					den_q[i] <= den_q[i-1];
				end
			end
		end
	end

	// Apply the sign and clip to the coordinate range
	assign pos_lim = QB'($unsigned(tpf_pkg::COORD_MAX));
	assign neg_lim = pos_lim + 1'b1;
	assign mag     = quo_q[QB][CW-1:0];

	always_comb begin
		if (neg_q[QB]) begin
			clip = ovf_q[QB] || (quo_q[QB] > neg_lim);
			quo  = clip ? tpf_pkg::COORD_MIN : tpf_pkg::coord_t'(-mag);
		end else begin
			clip = ovf_q[QB] || (quo_q[QB] > pos_lim);
			quo  = clip ? tpf_pkg::COORD_MAX : tpf_pkg::coord_t'(mag);
		end
	end

endmodule

>>> hdl/tpf_back.sv
`timescale 1ns / 1ps
// Back end: determinant, numerators, division, offset and saturation for each fit.
module tpf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tpf_pkg::fit_t   head,
	input  logic            avail,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output tpf_pkg::coord_t slope_x,
	output tpf_pkg::coord_t slope_y,
	output tpf_pkg::coord_t offset,
	output logic            degenerate,
	output logic            saturated,
	output logic            last_out
);

	localparam int DW  = tpf_pkg::DW;
	localparam int PW  = tpf_pkg::PW;
	localparam int NW  = tpf_pkg::NW;
	localparam int SW  = tpf_pkg::SW;
	localparam int CW  = tpf_pkg::CW;
	localparam int CPW = tpf_pkg::CPW;
	localparam int FRAC = tpf_pkg::FRAC;
	localparam int DL  = tpf_pkg::DIVLAT;

	logic en;

	// Stage 1: differences
	logic                  v_s1;
	logic signed [DW-1:0]  x02_s1, y02_s1, z02_s1, x12_s1, y12_s1, z12_s1;
	tpf_pkg::coord_t       x2_s1, y2_s1, z2_s1;
	logic                  last_s1;
	// Stage 2: products
	logic                  v_s2;
	logic signed [PW-1:0]  pxy_s2, pyx_s2, pzy_s2, pyz_s2, pxz_s2, pzx_s2;
	tpf_pkg::coord_t       x2_s2, y2_s2, z2_s2;
	logic                  last_s2;
	// Stage 3: determinant and numerators
	logic                  v_s3;
	logic signed [NW-1:0]  d_s3, na_s3, nb_s3;
	tpf_pkg::coord_t       x2_s3, y2_s3, z2_s3;
	logic                  last_s3;
	// Stage 4: magnitudes for the dividers
	logic                  v_s4;
	logic [SW-1:0]         nam_s4, nbm_s4;
	logic [NW-1:0]         dm_s4;
	logic                  nega_s4, negb_s4;
	tpf_pkg::side_t        side_s4;
	// Divider shadow
	logic                  vd_q [0:DL-1];
	tpf_pkg::side_t        sd_q [0:DL-1];
	tpf_pkg::coord_t       qa, qb;
	logic                  clipa, clipb;
	// Stage 5: slopes
	logic                  v_s5;
	tpf_pkg::coord_t       a_s5, b_s5;
	logic                  clip_s5;
	tpf_pkg::side_t        side_s5;
	// Stage 6: offset products
	logic                  v_s6;
	logic signed [2*CW-1:0] pax_s6, pby_s6;
	logic signed [CPW-1:0] zsh_s6;
	tpf_pkg::coord_t       a_s6, b_s6;
	logic                  clip_s6;
	logic                  last_s6, degen_s6;
	// Stage 7: offset sum
	logic                  v_s7;
	logic signed [CPW-1:0] cc_s7;
	tpf_pkg::coord_t       a_s7, b_s7;
	logic                  clip_s7;
	logic                  last_s7, degen_s7;
	// Stage 8: truncated offset
	logic                  v_s8;
	logic signed [CPW-1:0] ct_s8;
	tpf_pkg::coord_t       a_s8, b_s8;
	logic                  clip_s8;
	logic                  last_s8, degen_s8;

	logic [NW-1:0]         na_mag, nb_mag, d_mag;
	logic [CPW-1:0]        cc_mag;
	logic [CPW-1:0]        cc_sh;
	logic                  clip_c;
	tpf_pkg::coord_t       c_sat;

	// Advance the whole pipeline unless the result register is held
	assign en  = !result_valid || !result_stall;
	assign pop = en && avail;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= avail;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= vd_q[DL-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			result_valid <= v_s8;
		end
	end

	// Stages 1 to 3: differences, products, determinant and numerators
	always_ff @(posedge clk) begin
		if (en) begin
			x02_s1  <= DW'(head.x0) - DW'(head.x2);
			y02_s1  <= DW'(head.y0) - DW'(head.y2);
			z02_s1  <= DW'(head.z0) - DW'(head.z2);
			x12_s1  <= DW'(head.x1) - DW'(head.x2);
			y12_s1  <= DW'(head.y1) - DW'(head.y2);
			z12_s1  <= DW'(head.z1) - DW'(head.z2);
			x2_s1   <= head.x2;
			y2_s1   <= head.y2;
			z2_s1   <= head.z2;
			last_s1 <= head.last;

			pxy_s2  <= x02_s1 * y12_s1;
			pyx_s2  <= x12_s1 * y02_s1;
			pzy_s2  <= z02_s1 * y12_s1;
			pyz_s2  <= z12_s1 * y02_s1;
			pxz_s2  <= x02_s1 * z12_s1;
			pzx_s2  <= x12_s1 * z02_s1;
			x2_s2   <= x2_s1;
			y2_s2   <= y2_s1;
			z2_s2   <= z2_s1;
			last_s2 <= last_s1;

			d_s3    <= NW'(pxy_s2) - NW'(pyx_s2);
			na_s3   <= NW'(pzy_s2) - NW'(pyz_s2);
			nb_s3   <= NW'(pxz_s2) - NW'(pzx_s2);
			x2_s3   <= x2_s2;
			y2_s3   <= y2_s2;
			z2_s3   <= z2_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage 4: take magnitudes and signs of the quotients
	assign na_mag = na_s3[NW-1] ? NW'(-na_s3) : NW'(na_s3);
	assign nb_mag = nb_s3[NW-1] ? NW'(-nb_s3) : NW'(nb_s3);
	assign d_mag  = d_s3[NW-1] ? NW'(-d_s3) : NW'(d_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			nam_s4        <= SW'(na_mag) << FRAC;
			nbm_s4        <= SW'(nb_mag) << FRAC;
			dm_s4         <= d_mag;
			nega_s4       <= na_s3[NW-1] ^ d_s3[NW-1];
			negb_s4       <= nb_s3[NW-1] ^ d_s3[NW-1];
			side_s4.x2    <= x2_s3;
			side_s4.y2    <= y2_s3;
			side_s4.z2    <= z2_s3;
			side_s4.last  <= last_s3;
			side_s4.degen <= d_s3 == '0;
		end
	end

	tpf_div u_div_a (
		.clk(clk), .en(en), .num(nam_s4), .den(dm_s4), .neg(nega_s4),
		.quo(qa), .clip(clipa)
	);
	tpf_div u_div_b (
		.clk(clk), .en(en), .num(nbm_s4), .den(dm_s4), .neg(negb_s4),
		.quo(qb), .clip(clipb)
	);

	// Carry corner data alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) begin
				vd_q[i] <= 1'b0;
			end
		end else if (en) begin
			vd_q[0] <= v_s4;
			for (int i = 1; i < DL; i++) begin
				vd_q[i] <= vd_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[0] <= side_s4;
			for (int i = 1; i < DL; i++) begin
				sd_q[i] <= sd_q[i-1];
			end
		end
	end

	// Stages 5 to 8: slopes, offset products, sum and truncation
	always_ff @(posedge clk) begin
		if (en) begin
			a_s5     <= qa;
			b_s5     <= qb;
			clip_s5  <= clipa || clipb;
			side_s5  <= sd_q[DL-1];

			pax_s6   <= a_s5 * side_s5.x2;
			pby_s6   <= b_s5 * side_s5.y2;
			zsh_s6   <= CPW'(side_s5.z2) <<< FRAC;
			a_s6     <= a_s5;
			b_s6     <= b_s5;
			clip_s6  <= clip_s5;
			last_s6  <= side_s5.last;
			degen_s6 <= side_s5.degen;

			cc_s7    <= zsh_s6 - CPW'(pax_s6) - CPW'(pby_s6);
			a_s7     <= a_s6;
			b_s7     <= b_s6;
			clip_s7  <= clip_s6;
			last_s7  <= last_s6;
			degen_s7 <= degen_s6;

			ct_s8    <= cc_s7[CPW-1] ? -$signed(cc_sh) : $signed(cc_sh);
			a_s8     <= a_s7;
			b_s8     <= b_s7;
			clip_s8  <= clip_s7;
			last_s8  <= last_s7;
			degen_s8 <= degen_s7;
		end
	end

	// Truncate toward zero: shift the magnitude
	assign cc_mag = cc_s7[CPW-1] ? CPW'(-cc_s7) : CPW'(cc_s7);
	assign cc_sh  = cc_mag >> FRAC;

	// Clip the offset
	always_comb begin
		clip_c = 1'b0;
		c_sat  = tpf_pkg::coord_t'(ct_s8);
		if (ct_s8 > CPW'(tpf_pkg::COORD_MAX)) begin
			clip_c = 1'b1;
			c_sat  = tpf_pkg::COORD_MAX;
		end else if (ct_s8 < CPW'(tpf_pkg::COORD_MIN)) begin
			clip_c = 1'b1;
			c_sat  = tpf_pkg::COORD_MIN;
		end
	end

	// Result register; collinear corners give all zeros
	always_ff @(posedge clk) begin
		if (en) begin
			slope_x    <= degen_s8 ? '0 : a_s8;
			slope_y    <= degen_s8 ? '0 : b_s8;
			offset     <= degen_s8 ? '0 : c_sat;
			saturated  <= !degen_s8 && (clip_s8 || clip_c);
			degenerate <= degen_s8;
			last_out   <= last_s8;
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && degenerate) |->
		(slope_x == '0 && slope_y == '0 && offset == '0 && !saturated))
		else $error("collinear result carries nonzero coefficients");

	a_pop_advance: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped transaction lost before first stage");

endmodule

>>> hdl/triangle_plane_fit.sv
`timescale 1ns / 1ps
// Top level of the triangle plane fit block.
//
// Load transactions (cmd 0) write x, y, z into the vertex store; fit
// transactions (cmd 1) read three stored corners and return the plane
// z = slope_x*x + slope_y*y + offset, slopes in signed Q16.16 and the
// offset in coordinate units, saturated, with degenerate set and zero
// coefficients for collinear corners. One transaction is taken every
// cycle when the result side keeps up; a fit passes through the store
// read, the queue, the two pipelined dividers (a load stage and then one
// quotient bit per stage, 34 stages in all) and the multiply stages.
// The store is held three times so that the three corners are read in the
// same cycle; an entry never written reads as anything. There is no
// clearing pass after reset.
module triangle_plane_fit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     cmd,
	input  logic [tpf_pkg::IDXW-1:0] vertex_index,
	input  tpf_pkg::coord_t          coord_x,
	input  tpf_pkg::coord_t          coord_y,
	input  tpf_pkg::coord_t          coord_z,
	input  logic [tpf_pkg::IDXW-1:0] node_a,
	input  logic [tpf_pkg::IDXW-1:0] node_b,
	input  logic [tpf_pkg::IDXW-1:0] node_c,
	input  logic                     last_in,
	output logic                     result_valid,
	input  logic                     result_stall,
	output tpf_pkg::coord_t          slope_x,
	output tpf_pkg::coord_t          slope_y,
	output tpf_pkg::coord_t          offset,
	output logic                     degenerate,
	output logic                     saturated,
	output logic                     last_out
);

	tpf_pkg::push_t          push;
	tpf_pkg::fit_t           head;
	logic [tpf_pkg::QCW-1:0] q_level;
	logic                    avail;
	logic                    pop;

	tpf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(cmd), .vertex_index(vertex_index),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.node_a(node_a), .node_b(node_b), .node_c(node_c),
		.last_in(last_in), .q_level(q_level), .push(push)
	);

	tpf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .pop(pop),
		.level(q_level), .avail(avail), .head(head)
	);

	tpf_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .avail(avail), .pop(pop),
		.result_valid(result_valid), .result_stall(result_stall),
		.slope_x(slope_x), .slope_y(slope_y), .offset(offset),
		.degenerate(degenerate), .saturated(saturated), .last_out(last_out)
	);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for triangle_plane_fit: vertex loads and plane fits against a local predictor.
module tb_top;
	import tpf_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_LEN   = 300;
	localparam int N_RANDOM   = 700;

	typedef struct {
		coord_t sx;
		coord_t sy;
		coord_t off;
		logic   deg;
		logic   sat;
		logic   last;
	} plane_t;

	typedef struct {
		cmd_t        op;
		logic [9:0]  idx;
		coord_t      x;
		coord_t      y;
		coord_t      z;
		logic [9:0]  na;
		logic [9:0]  nb;
		logic [9:0]  nc;
		logic        last;
		bit          typed;
		plane_t      want;
	} txn_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic cmd = 1'b0;
	logic [IDXW-1:0] vertex_index = '0;
	coord_t coord_x = '0, coord_y = '0, coord_z = '0;
	logic [IDXW-1:0] node_a = '0, node_b = '0, node_c = '0;
	logic last_in = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	coord_t slope_x, slope_y, offset;
	logic degenerate, saturated, last_out;

	// predictor state: vertex store copy and bookkeeping
	coord_t store_x [VERTEX_DEPTH];
	coord_t store_y [VERTEX_DEPTH];
	coord_t store_z [VERTEX_DEPTH];
	bit     is_loaded [VERTEX_DEPTH];
	int     loaded_list [$];
	plane_t planes_due [$];

	int  n_fail = 0;
	int  n_loads = 0, n_fits = 0, n_degen = 0, n_sat = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;
	bit  hold_req = 1'b0;

	triangle_plane_fit DUT (.*);

	always #4 clk = ~clk;

	// saturate a wide signed value into a coordinate
	function automatic coord_t clip_coord(input logic signed [127:0] v, inout logic hit);
		logic signed [127:0] hi_lim, lo_lim;
		hi_lim = 128'sd2147483647;
		lo_lim = -128'sd2147483648;
		if (v > hi_lim) begin
			hit = 1'b1;
			return COORD_MAX;
		end
		if (v < lo_lim) begin
			hit = 1'b1;
			return COORD_MIN;
		end
		return coord_t'(v[CW-1:0]);
	endfunction

	// plane through three stored corners, node c the reference
	function automatic plane_t plane_fit(input logic [9:0] ia, ib, ic, input logic lst);
		logic signed [127:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
		logic signed [127:0] x02, y02, z02, x12, y12, z12, det, num_a, num_b, cc;
		plane_t p;
		x0 = store_x[ia]; y0 = store_y[ia]; z0 = store_z[ia];
		x1 = store_x[ib]; y1 = store_y[ib]; z1 = store_z[ib];
		x2 = store_x[ic]; y2 = store_y[ic]; z2 = store_z[ic];
		x02 = x0 - x2; y02 = y0 - y2; z02 = z0 - z2;
		x12 = x1 - x2; y12 = y1 - y2; z12 = z1 - z2;
		p = '{sx: '0, sy: '0, off: '0, deg: 1'b0, sat: 1'b0, last: lst};
		det = x02 * y12 - x12 * y02;
		if (det == 0) begin
			p.deg = 1'b1;
			return p;
		end
		num_a = z02 * y12 - z12 * y02;
		num_b = x02 * z12 - x12 * z02;
		p.sx = clip_coord((num_a <<< FRAC) / det, p.sat);
		p.sy = clip_coord((num_b <<< FRAC) / det, p.sat);
		cc = (z2 <<< FRAC) - 128'(signed'(p.sx)) * x2 - 128'(signed'(p.sy)) * y2;
		// signed division truncates toward zero
		p.off = clip_coord(cc / 128'sd65536, p.sat);
		return p;
	endfunction

	function automatic txn_t load_txn(input logic [9:0] i, input coord_t x, y, z);
		txn_t t;
		t = '{op: CMD_LOAD, idx: i, x: x, y: y, z: z, na: '0, nb: '0, nc: '0,
			last: 1'b0, typed: 1'b0, want: '{'0, '0, '0, 1'b0, 1'b0, 1'b0}};
		return t;
	endfunction

	function automatic txn_t fit_txn(input logic [9:0] a, b, c, input logic lst);
		txn_t t;
		t = '{op: CMD_FIT, idx: 10'($urandom), x: coord_t'($urandom),
			y: coord_t'($urandom), z: coord_t'($urandom),
			na: a, nb: b, nc: c, last: lst, typed: 1'b0,
			want: '{'0, '0, '0, 1'b0, 1'b0, 1'b0}};
		return t;
	endfunction

	// offer one transaction and update the predictor once it is taken
	task automatic offer(input txn_t t);
		item_valid <= 1'b1;
		cmd <= t.op;
		vertex_index <= t.idx;
		coord_x <= t.x;
		coord_y <= t.y;
		coord_z <= t.z;
		node_a <= t.na;
		node_b <= t.nb;
		node_c <= t.nc;
		last_in <= t.last;
		do @(posedge clk); while (item_stall);
		if (t.op == CMD_LOAD) begin
			store_x[t.idx] = t.x;
			store_y[t.idx] = t.y;
			store_z[t.idx] = t.z;
			if (!is_loaded[t.idx]) loaded_list.push_back(int'(t.idx));
			is_loaded[t.idx] = 1'b1;
			n_loads++;
		end else begin
			planes_due.push_back(t.typed ? t.want : plane_fit(t.na, t.nb, t.nc, t.last));
			n_fits++;
		end
	endtask

	task automatic idle_sender(input int n);
		item_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3, 4, 5: return coord_t'($urandom);
			default: return coord_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
		endcase
	endfunction

	// check each result against the oldest expected plane
	always @(posedge clk) begin
		plane_t w;
		if (arst_n && result_valid && !result_stall) begin
			if (planes_due.size() == 0) begin
				$error("result with no fit outstanding");
				n_fail++;
			end else begin
				w = planes_due.pop_front();
				if (slope_x !== w.sx) begin
					$error("slope_x exp %0d got %0d", w.sx, slope_x);
					n_fail++;
				end
				if (slope_y !== w.sy) begin
					$error("slope_y exp %0d got %0d", w.sy, slope_y);
					n_fail++;
				end
				if (offset !== w.off) begin
					$error("offset exp %0d got %0d", w.off, offset);
					n_fail++;
				end
				if (degenerate !== w.deg) begin
					$error("degenerate exp %0b got %0b", w.deg, degenerate);
					n_fail++;
				end
				if (saturated !== w.sat) begin
					$error("saturated exp %0b got %0b", w.sat, saturated);
					n_fail++;
				end
				if (last_out !== w.last) begin
					$error("last_out exp %0b got %0b", w.last, last_out);
					n_fail++;
				end
				n_degen += int'(w.deg);
				n_sat += int'(w.sat);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", planes_due.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// result side stalls: random bursts, one long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_LEN - 1) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				n = $urandom_range(1, 15);
				repeat (n - 1) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				n = $urandom_range(1, 25);
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		txn_t plan [$];
		txn_t t;
		int   a, b, c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: flat plane, unit slope, repeated corner, extremes, saturation
		plan.push_back(load_txn(10'd0, '0, '0, '0));
		plan.push_back(load_txn(10'd1, 32'sh10000, '0, '0));
		plan.push_back(load_txn(10'd2, '0, 32'sh10000, '0));
		t = fit_txn(10'd0, 10'd1, 10'd2, 1'b0);
		t.typed = 1'b1;
		t.want = '{'0, '0, '0, 1'b0, 1'b0, 1'b0};
		plan.push_back(t);
		plan.push_back(load_txn(10'd3, 32'sh10000, '0, 32'sh10000));
		t = fit_txn(10'd0, 10'd3, 10'd2, 1'b1);
		t.typed = 1'b1;
		t.want = '{32'sh10000, '0, '0, 1'b0, 1'b0, 1'b1};
		plan.push_back(t);
		t = fit_txn(10'd1, 10'd1, 10'd2, 1'b1);
		t.typed = 1'b1;
		t.want = '{'0, '0, '0, 1'b1, 1'b0, 1'b1};
		plan.push_back(t);
		plan.push_back(load_txn(10'd1023, COORD_MAX, COORD_MAX, COORD_MAX));
		plan.push_back(load_txn(10'd512, COORD_MIN, COORD_MAX, COORD_MIN));
		plan.push_back(load_txn(10'd341, COORD_MAX, COORD_MIN, '0));
		plan.push_back(load_txn(10'd682, 32'sd1, '0, COORD_MAX));
		plan.push_back(fit_txn(10'd1023, 10'd512, 10'd341, 1'b0));
		plan.push_back(fit_txn(10'd0, 10'd682, 10'd2, 1'b1));
		plan.push_back(fit_txn(10'd682, 10'd512, 10'd1023, 1'b0));
		plan.push_back(fit_txn(10'd341, 10'd0, 10'd1023, 1'b1));
		plan.push_back(fit_txn(10'd2, 10'd2, 10'd2, 1'b0));
		foreach (plan[i]) offer(plan[i]);

		// random: mostly fits over loaded corners, loads scattered over the store
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= N_RANDOM - 80);
			if (i == 250) hold_req = 1'b1;
			if (i == 450) begin
				item_valid <= 1'b0;
				wait (planes_due.size() == 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 2) == 0) begin
				t = load_txn(10'($urandom), rand_coord(), rand_coord(), rand_coord());
			end else begin
				a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				// repeated corner now and then forces a collinear triangle
				if ($urandom_range(0, 9) == 0) b = a;
				t = fit_txn(10'(a), 10'(b), 10'(c), 1'($urandom));
			end
			offer(t);
			if (!calm && !hold_req && $urandom_range(0, 7) == 0)
				idle_sender($urandom_range(1, 15));
		end
		item_valid <= 1'b0;

		wait (planes_due.size() == 0);
		repeat (60) @(posedge clk);
		$display("covered %0d loads, %0d fits (%0d collinear, %0d clipped)",
			n_loads, n_fits, n_degen, n_sat);
		$display("with long result hold, drain pause and random idling on both sides");
		if (n_fail == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> triangle_plane_fit.f
hdl/tpf_pkg.sv
hdl/tpf_ram.sv
hdl/tpf_front.sv
hdl/tpf_queue.sv
hdl/tpf_div.sv
hdl/tpf_back.sv
hdl/triangle_plane_fit.sv
dv/tb_top.sv
